@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define OWBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked only on clock edges while reset is asserted.
`define OWBM_ASSERT_IN_RESET(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) !rst_n |-> prop) else $error(msg);

`endif

@@ src/owbm_pkg.sv @@
// Types, codes and constants of the single-wire bus master.
package owbm_pkg;

  localparam int COUNTER_BITS_DEFAULT = 20;

  localparam int CFG_COUNT  = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RESET_LOW        = 3'd0,
    CFG_PRESENCE_TIMEOUT = 3'd1,
    CFG_RESET_TAIL       = 3'd2,
    CFG_WRITE_ZERO_LOW   = 3'd3,
    CFG_WRITE_ONE_LOW    = 3'd4,
    CFG_SLOT_TAIL        = 3'd5,
    CFG_READ_LOW         = 3'd6,
    CFG_READ_SAMPLE      = 3'd7
  } cfg_idx_e;

  // Reset values of the timing registers.
  localparam logic [15:0] RESET_LOW_RESET        = 16'd480;
  localparam logic [19:0] PRESENCE_TIMEOUT_RESET = 20'd100000;
  localparam logic [15:0] RESET_TAIL_RESET       = 16'd300;
  localparam logic [15:0] WRITE_ZERO_LOW_RESET   = 16'd60;
  localparam logic [15:0] WRITE_ONE_LOW_RESET    = 16'd1;
  localparam logic [15:0] SLOT_TAIL_RESET        = 16'd60;
  localparam logic [15:0] READ_LOW_RESET         = 16'd10;
  localparam logic [15:0] READ_SAMPLE_RESET      = 16'd15;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic {
    ST_OK          = 1'b0,
    ST_NO_PRESENCE = 1'b1
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_WAIT_LOW  = 4'd2,
    PH_WAIT_HIGH = 4'd3,
    PH_RST_TAIL  = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_TAIL   = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_WAIT   = 4'd8,
    PH_RD_SAMPLE = 4'd9,
    PH_RD_TAIL   = 4'd10
  } phase_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] byte_in;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    status_e    status;
    logic [7:0] byte_out;
  } out_item_t;

endpackage

@@ src/one_wire_bus_master.sv @@
// Single-wire bus master: one request per timing tick, one result per request.
//
// Usage: every request on the input channel is one tick of the bus waveform.
// It carries the sampled line level and, while no command runs, may start a
// bus reset with presence detect, a byte write or a byte read (LSB first).
// Each request yields exactly one result on the output channel: the pull-low
// drive for that tick, busy, done, the status and, on the done tick of a
// read, the assembled byte.
// Latency: the result of a request is valid in the cycle after it is taken.
// Throughput: one request per cycle while no result is stalled; the whole
// tick is evaluated combinationally by the phase state machine between the
// command state registers and the result register.
// Stall: the result register holds its item while out_ready_i is low; a new
// request is taken in the cycle the held result leaves, so in_ready_o follows
// out_ready_i whenever a result is pending.
// Reset: asynchronous and active low; the bus master returns to idle, the
// result register empties and the timing registers take their default values.
// The user must write timing registers through the plain write port only while idle; unenforced.
module one_wire_bus_master #(
  parameter int CounterBits = owbm_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  owbm_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output owbm_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [owbm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [owbm_pkg::CFG_COUNT-1:0][CounterBits-1:0] lim;

  owbm_cfg_regs #(
    .CounterBits(CounterBits)
  ) u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .lim_o      (lim)
  );

  owbm_pkg::phase_e    phase_q, phase_d;
  owbm_pkg::op_e       kind_q, kind_d;
  logic [CounterBits-1:0] cnt_q, cnt_d;
  logic [CounterBits-1:0] budget_q, budget_d;
  logic [2:0]          bit_q, bit_d;
  logic [7:0]          shift_q, shift_d;
  logic                out_valid_q;
  owbm_pkg::out_item_t out_q, out_d;

  // State after a possible command start in this tick.
  owbm_pkg::phase_e    st_phase;
  owbm_pkg::op_e       st_kind;
  logic [CounterBits-1:0] st_cnt;
  logic [2:0]          st_bit;
  logic [7:0]          st_shift;
  logic                wr_slot_end;
  logic                rd_slot_end;
  logic                accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    st_phase = phase_q;
    st_kind  = kind_q;
    st_cnt   = cnt_q;
    st_bit   = bit_q;
    st_shift = shift_q;
    if (phase_q == owbm_pkg::PH_IDLE && in_data_i.op != owbm_pkg::OP_TICK) begin
      st_kind = in_data_i.op;
      st_bit  = '0;
      case (in_data_i.op)
        owbm_pkg::OP_RESET: begin
          st_phase = owbm_pkg::PH_RST_LOW;
          st_cnt   = lim[owbm_pkg::CFG_RESET_LOW];
        end
        owbm_pkg::OP_WRITE: begin
          st_shift = in_data_i.byte_in;
          st_phase = owbm_pkg::PH_WR_LOW;
          st_cnt   = in_data_i.byte_in[0] ? lim[owbm_pkg::CFG_WRITE_ONE_LOW]
                                          : lim[owbm_pkg::CFG_WRITE_ZERO_LOW];
        end
        default: begin
          st_shift = '0;
          st_phase = owbm_pkg::PH_RD_LOW;
          st_cnt   = lim[owbm_pkg::CFG_READ_LOW];
        end
      endcase
    end

    phase_d     = st_phase;
    kind_d      = st_kind;
    cnt_d       = st_cnt;
    budget_d    = budget_q;
    bit_d       = st_bit;
    shift_d     = st_shift;
    wr_slot_end = 1'b0;
    rd_slot_end = 1'b0;
    out_d       = '0;

    case (st_phase)
      owbm_pkg::PH_IDLE: begin
      end
      owbm_pkg::PH_WAIT_LOW, owbm_pkg::PH_WAIT_HIGH: begin
        out_d.busy_res = 1'b1;
        if (st_phase == owbm_pkg::PH_WAIT_LOW && !in_data_i.line_level) begin
          phase_d = owbm_pkg::PH_WAIT_HIGH;
        end else if (st_phase == owbm_pkg::PH_WAIT_HIGH && in_data_i.line_level) begin
          cnt_d = lim[owbm_pkg::CFG_RESET_TAIL];
          if (lim[owbm_pkg::CFG_RESET_TAIL] != '0) begin
            phase_d = owbm_pkg::PH_RST_TAIL;
          end else begin
            phase_d        = owbm_pkg::PH_IDLE;
            out_d.done_res = 1'b1;
          end
        end else if (budget_q <= CounterBits'(1)) begin
          budget_d       = '0;
          phase_d        = owbm_pkg::PH_IDLE;
          out_d.done_res = 1'b1;
          out_d.status   = owbm_pkg::ST_NO_PRESENCE;
        end else begin
          budget_d = budget_q - CounterBits'(1);
        end
      end
      owbm_pkg::PH_RD_SAMPLE: begin
        out_d.busy_res = 1'b1;
        shift_d = {in_data_i.line_level, st_shift[7:1]};
        cnt_d   = lim[owbm_pkg::CFG_SLOT_TAIL];
        if (lim[owbm_pkg::CFG_SLOT_TAIL] != '0) begin
          phase_d = owbm_pkg::PH_RD_TAIL;
        end else begin
          rd_slot_end = 1'b1;
        end
      end
      default: begin
        out_d.busy_res  = 1'b1;
        out_d.drive_low = (st_phase == owbm_pkg::PH_RST_LOW) ||
                          (st_phase == owbm_pkg::PH_WR_LOW) ||
                          (st_phase == owbm_pkg::PH_RD_LOW);
        if (st_cnt <= CounterBits'(1)) begin
          cnt_d = '0;
          case (st_phase)
            owbm_pkg::PH_RST_LOW: begin
              phase_d  = owbm_pkg::PH_WAIT_LOW;
              budget_d = lim[owbm_pkg::CFG_PRESENCE_TIMEOUT];
            end
            owbm_pkg::PH_RST_TAIL: begin
              phase_d        = owbm_pkg::PH_IDLE;
              out_d.done_res = 1'b1;
            end
            owbm_pkg::PH_WR_LOW: begin
              cnt_d = lim[owbm_pkg::CFG_SLOT_TAIL];
              if (lim[owbm_pkg::CFG_SLOT_TAIL] != '0) begin
                phase_d = owbm_pkg::PH_WR_TAIL;
              end else begin
                wr_slot_end = 1'b1;
              end
            end
            owbm_pkg::PH_WR_TAIL: begin
              wr_slot_end = 1'b1;
            end
            owbm_pkg::PH_RD_LOW: begin
              cnt_d   = lim[owbm_pkg::CFG_READ_SAMPLE];
              phase_d = (lim[owbm_pkg::CFG_READ_SAMPLE] != '0) ?
                        owbm_pkg::PH_RD_WAIT : owbm_pkg::PH_RD_SAMPLE;
            end
            owbm_pkg::PH_RD_WAIT: begin
              phase_d = owbm_pkg::PH_RD_SAMPLE;
            end
            owbm_pkg::PH_RD_TAIL: begin
              rd_slot_end = 1'b1;
            end
            default: begin
              phase_d = owbm_pkg::PH_IDLE;
            end
          endcase
        end else begin
          cnt_d = st_cnt - CounterBits'(1);
        end
      end
    endcase

    // End of a bit slot: either the byte is complete or the next slot opens.
    if (wr_slot_end) begin
      shift_d = {1'b0, st_shift[7:1]};
      if (st_bit == 3'd7) begin
        bit_d          = '0;
        phase_d        = owbm_pkg::PH_IDLE;
        out_d.done_res = 1'b1;
      end else begin
        bit_d   = st_bit + 3'd1;
        phase_d = owbm_pkg::PH_WR_LOW;
        cnt_d   = st_shift[1] ? lim[owbm_pkg::CFG_WRITE_ONE_LOW]
                              : lim[owbm_pkg::CFG_WRITE_ZERO_LOW];
      end
    end
    if (rd_slot_end) begin
      if (st_bit == 3'd7) begin
        bit_d          = '0;
        phase_d        = owbm_pkg::PH_IDLE;
        out_d.done_res = 1'b1;
      end else begin
        bit_d   = st_bit + 3'd1;
        phase_d = owbm_pkg::PH_RD_LOW;
        cnt_d   = lim[owbm_pkg::CFG_READ_LOW];
      end
    end

    if (out_d.done_res && kind_d == owbm_pkg::OP_READ) begin
      out_d.byte_out = shift_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= owbm_pkg::PH_IDLE;
      kind_q   <= owbm_pkg::OP_TICK;
      cnt_q    <= '0;
      budget_q <= '0;
      bit_q    <= '0;
      shift_q  <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      cnt_q    <= cnt_d;
      budget_q <= budget_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/owbm_cfg_regs.sv @@
// Timing register file with timeout saturation to the counter width and low-time floors.
module owbm_cfg_regs #(
  parameter int CounterBits = owbm_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [owbm_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [owbm_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  output logic [owbm_pkg::CFG_COUNT-1:0][CounterBits-1:0] lim_o
);

  localparam int HiW = owbm_pkg::CFG_DATA_W - 16;

  // Lower 16 bits of every register; the presence timeout keeps its upper bits apart.
  logic [owbm_pkg::CFG_COUNT-1:0][15:0] reg_q;
  logic [HiW-1:0]                        timeout_hi_q;
  logic [owbm_pkg::CFG_DATA_W-1:0]       timeout_full;
  logic [CounterBits-1:0]                timeout_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q[owbm_pkg::CFG_RESET_LOW]        <= owbm_pkg::RESET_LOW_RESET;
      reg_q[owbm_pkg::CFG_PRESENCE_TIMEOUT] <= owbm_pkg::PRESENCE_TIMEOUT_RESET[15:0];
      reg_q[owbm_pkg::CFG_RESET_TAIL]       <= owbm_pkg::RESET_TAIL_RESET;
      reg_q[owbm_pkg::CFG_WRITE_ZERO_LOW]   <= owbm_pkg::WRITE_ZERO_LOW_RESET;
      reg_q[owbm_pkg::CFG_WRITE_ONE_LOW]    <= owbm_pkg::WRITE_ONE_LOW_RESET;
      reg_q[owbm_pkg::CFG_SLOT_TAIL]        <= owbm_pkg::SLOT_TAIL_RESET;
      reg_q[owbm_pkg::CFG_READ_LOW]         <= owbm_pkg::READ_LOW_RESET;
      reg_q[owbm_pkg::CFG_READ_SAMPLE]      <= owbm_pkg::READ_SAMPLE_RESET;
      timeout_hi_q <= owbm_pkg::PRESENCE_TIMEOUT_RESET[owbm_pkg::CFG_DATA_W-1:16];
    end else if (cfg_we_i) begin
      reg_q[cfg_addr_i] <= cfg_wdata_i[15:0];
      if (cfg_addr_i == owbm_pkg::CFG_PRESENCE_TIMEOUT) begin
        timeout_hi_q <= cfg_wdata_i[owbm_pkg::CFG_DATA_W-1:16];
      end
    end
  end

  assign timeout_full = {timeout_hi_q, reg_q[owbm_pkg::CFG_PRESENCE_TIMEOUT]};

  // A timeout wider than the counters saturates at the largest count.
  if (CounterBits >= owbm_pkg::CFG_DATA_W) begin : g_timeout_fits
    assign timeout_lim = CounterBits'(timeout_full);
  end else begin : g_timeout_sat
    assign timeout_lim = (timeout_full[owbm_pkg::CFG_DATA_W-1:CounterBits] != '0) ?
                         '1 : timeout_full[CounterBits-1:0];
  end

  always_comb begin
    for (int i = 0; i < owbm_pkg::CFG_COUNT; i++) begin
      lim_o[i] = CounterBits'(reg_q[i]);
    end
    lim_o[owbm_pkg::CFG_PRESENCE_TIMEOUT] = timeout_lim;
    // Low times of zero behave as one tick.
    if (reg_q[owbm_pkg::CFG_RESET_LOW] == '0) begin
      lim_o[owbm_pkg::CFG_RESET_LOW] = CounterBits'(1);
    end
    if (reg_q[owbm_pkg::CFG_WRITE_ZERO_LOW] == '0) begin
      lim_o[owbm_pkg::CFG_WRITE_ZERO_LOW] = CounterBits'(1);
    end
    if (reg_q[owbm_pkg::CFG_WRITE_ONE_LOW] == '0) begin
      lim_o[owbm_pkg::CFG_WRITE_ONE_LOW] = CounterBits'(1);
    end
    if (reg_q[owbm_pkg::CFG_READ_LOW] == '0) begin
      lim_o[owbm_pkg::CFG_READ_LOW] = CounterBits'(1);
    end
  end

endmodule

@@ src/owbm_checker.sv @@
// Port-level checker for the single-wire bus master and its bind.
`include "assert_macros.svh"

module owbm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input owbm_pkg::out_item_t out_data_o
);

  logic in_acc;
  logic act_res;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_o;
  assign act_res   = out_valid_o && (out_data_o.done_res || out_data_o.drive_low);
  assign out_stall = out_valid_o && !out_ready_i;

  // No result may be pending while reset is held.
  `OWBM_ASSERT_IN_RESET(a_no_result_in_reset, clk_i, rst_ni, !out_valid_o, "result in reset")

  // A taken result always frees room for the next request.
  `OWBM_ASSERT(a_ready_sink, clk_i, rst_ni, out_ready_i |-> in_ready_o, "input blocked")

  // Every accepted request gives a result in the next cycle.
  `OWBM_ASSERT(a_result_next, clk_i, rst_ni, in_acc |=> out_valid_o, "request lost")

  // Drive and completion only happen as part of a running command.
  `OWBM_ASSERT(a_busy, clk_i, rst_ni, act_res |-> out_data_o.busy_res, "activity while idle")

  // A stalled result keeps its payload.
  `OWBM_ASSERT(a_hold, clk_i, rst_ni, out_stall |=> $stable(out_data_o), "result changed")

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (.*);
